[sv/replay_arithmetic_op_list_assert.svh]
// Assertion macros for the op list replay block.
`ifndef REPLAY_ARITHMETIC_OP_LIST_ASSERT_SVH
`define REPLAY_ARITHMETIC_OP_LIST_ASSERT_SVH

`ifndef SYNTHESIS

`define RAO_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define RAO_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define RAO_ASSERT_IMPL(label, clk, rst, ante, cons)

`define RAO_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/rao_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rao_pkg;

  localparam int ADDR_W = 2;
  localparam logic [ADDR_W-1:0] ADDR_START_VALUE = 2'd0;

  localparam logic OPC_APPEND = 1'b0;
  localparam logic OPC_APPLY  = 1'b1;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  typedef logic [2:0] upc_t;

  localparam upc_t U_IDLE  = 3'd0;
  localparam upc_t U_START = 3'd1;
  localparam upc_t U_READ  = 3'd2;
  localparam upc_t U_EXEC  = 3'd3;
  localparam upc_t U_WAIT  = 3'd4;
  localparam upc_t U_NEXT  = 3'd5;
  localparam upc_t U_EMIT  = 3'd6;

  typedef logic [2:0] cond_t;

  localparam cond_t C_ALWAYS  = 3'd0;
  localparam cond_t C_APPLY   = 3'd1;
  localparam cond_t C_EMPTY   = 3'd2;
  localparam cond_t C_DIVGO   = 3'd3;
  localparam cond_t C_DIVDONE = 3'd4;
  localparam cond_t C_LAST    = 3'd5;
  localparam cond_t C_OUTFREE = 3'd6;

  typedef struct packed {
    logic in_rdy;
    logic init;
    logic rd;
    logic alu;
    logic div_start;
    logic acc_div;
    logic inc;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic apply;
    logic empty;
    logic divgo;
    logic divdone;
    logic last;
    logic outfree;
  } status_t;

  typedef struct packed {
    cond_t cond;
    upc_t  taken;
    upc_t  other;
    ctl_t  ctl;
  } uword_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] operand;
  } step_t;

  //                         in_rdy init rd alu dstart adiv inc emit
  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    unique case (pc)
      U_IDLE:  w = '{C_APPLY,   U_START, U_IDLE,  8'b1000_0000};
      U_START: w = '{C_EMPTY,   U_EMIT,  U_READ,  8'b0100_0000};
      U_READ:  w = '{C_ALWAYS,  U_EXEC,  U_EXEC,  8'b0010_0000};
      U_EXEC:  w = '{C_DIVGO,   U_WAIT,  U_NEXT,  8'b0001_1000};
      U_WAIT:  w = '{C_DIVDONE, U_NEXT,  U_WAIT,  8'b0000_0100};
      U_NEXT:  w = '{C_LAST,    U_EMIT,  U_READ,  8'b0000_0010};
      U_EMIT:  w = '{C_OUTFREE, U_IDLE,  U_EMIT,  8'b0000_0001};
      default: w = '{C_ALWAYS,  U_IDLE,  U_IDLE,  8'b0000_0000};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[sv/rao_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module rao_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic        done,
  output logic [31:0] quot
);

  logic [31:0] rem;
  logic [31:0] q;
  logic [31:0] d;
  logic        neg;
  logic [5:0]  cnt;
  logic [32:0] trial;

  assign busy  = (cnt != 6'd0);
  assign trial = {rem, q[31]} - {1'b0, d};
  assign quot  = neg ? (32'd0 - q) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 6'd0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 6'd1);
      if (start) begin
        cnt <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 32'd0;
      q   <= num[31] ? (32'd0 - num) : num;
      d   <= den[31] ? (32'd0 - den) : den;
      neg <= num[31] ^ den[31];
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        q   <= {q[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], q[31]};
        q   <= {q[30:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

[sv/rao_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

module rao_seq (
  input  logic              clk,
  input  logic              rst,
  input  rao_pkg::status_t  st,
  output rao_pkg::ctl_t     ctl
);

  rao_pkg::upc_t   upc;
  rao_pkg::uword_t uw;
  logic            hit;

  assign uw  = rao_pkg::ucode(upc);
  assign ctl = uw.ctl;

  always_comb begin
    unique case (uw.cond)
      rao_pkg::C_ALWAYS:  hit = 1'b1;
      rao_pkg::C_APPLY:   hit = st.apply;
      rao_pkg::C_EMPTY:   hit = st.empty;
      rao_pkg::C_DIVGO:   hit = st.divgo;
      rao_pkg::C_DIVDONE: hit = st.divdone;
      rao_pkg::C_LAST:    hit = st.last;
      rao_pkg::C_OUTFREE: hit = st.outfree;
      default:            hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= rao_pkg::U_IDLE;
    end else begin
      upc <= hit ? uw.taken : uw.other;
    end
  end

endmodule

`default_nettype wire

[sv/replay_arithmetic_op_list.sv]
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    opcode, step_kind, step_operand
// out       output     out_valid/out_ready  value, div_by_zero
// config    input      APB write            start_value at paddr 0
//
// Append: accepted while idle, next item may follow at once.
// Apply: replays the stored steps in order through the read, exec and next
// states; a division with a nonzero divisor waits on the bit-serial divider.
// Result sits in an output register; appends are taken while it waits.
// Reset is synchronous and holds in_ready low; the step store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "replay_arithmetic_op_list_assert.svh"

module replay_arithmetic_op_list #(
  parameter int OP_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        opcode,
  input  logic [1:0]                  step_kind,
  input  logic signed [31:0]          step_operand,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          value,
  output logic                        div_by_zero,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rao_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int IW = (OP_DEPTH > 1) ? $clog2(OP_DEPTH) : 1;
  localparam int CW = $clog2(OP_DEPTH + 1);

  rao_pkg::step_t   mem [OP_DEPTH];
  rao_pkg::step_t   rdata;
  rao_pkg::ctl_t    ctl;
  rao_pkg::status_t st;

  logic [CW-1:0] count;
  logic [IW-1:0] idx;
  logic [31:0]   start_value;
  logic [31:0]   acc;
  logic          started;
  logic          dz;
  logic          in_acc;
  logic          div_busy;
  logic          div_done;
  logic [31:0]   div_quot;
  logic          div_go;

  assign in_ready = ctl.in_rdy && !rst;
  assign in_acc   = in_valid && in_ready;
  assign pready   = 1'b1;
  assign prdata   = (paddr == rao_pkg::ADDR_START_VALUE) ? start_value : 32'd0;
  assign div_go   = ctl.div_start && st.divgo;

  assign st.apply   = in_acc && (opcode == rao_pkg::OPC_APPLY);
  assign st.empty   = (count == '0);
  assign st.divgo   = (rdata.kind == rao_pkg::KIND_DIV) && (rdata.operand != 32'd0);
  assign st.divdone = div_done;
  assign st.last    = (CW'(idx) == (count - CW'(1)));
  assign st.outfree = !out_valid || out_ready;

  rao_seq u_seq (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .ctl (ctl)
  );

  rao_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (acc),
    .den   (rdata.operand),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (in_acc && (opcode == rao_pkg::OPC_APPEND) && (count < CW'(OP_DEPTH))) begin
      mem[count[IW-1:0]] <= '{step_kind, step_operand};
    end
    if (ctl.rd) begin
      rdata <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      start_value <= 32'd0;
      started     <= 1'b0;
      acc         <= 32'd0;
      out_valid   <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr == rao_pkg::ADDR_START_VALUE)) begin
        start_value <= pwdata;
      end
      if (in_acc && (opcode == rao_pkg::OPC_APPEND) && (count < CW'(OP_DEPTH))) begin
        count <= count + CW'(1);
      end
      if (ctl.init) begin
        acc <= started ? acc : start_value;
      end else if (ctl.alu) begin
        unique case (rdata.kind)
          rao_pkg::KIND_ADD: acc <= acc + rdata.operand;
          rao_pkg::KIND_SUB: acc <= acc - rdata.operand;
          rao_pkg::KIND_MUL: acc <= acc * rdata.operand;
          default:           acc <= acc;
        endcase
      end else if (ctl.acc_div && div_done) begin
        acc <= div_quot;
      end
      if (ctl.emit && st.outfree) begin
        out_valid <= 1'b1;
        started   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      idx <= '0;
      dz  <= 1'b0;
    end else begin
      if (ctl.inc) begin
        idx <= idx + IW'(1);
      end
      if (ctl.alu && (rdata.kind == rao_pkg::KIND_DIV) && (rdata.operand == 32'd0)) begin
        dz <= 1'b1;
      end
    end
    if (ctl.emit && st.outfree) begin
      value       <= acc;
      div_by_zero <= dz;
    end
  end

  `RAO_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CW'(OP_DEPTH))
  `RAO_ASSERT_IMPL(a_div_in_wait, clk, rst, div_busy, ctl.acc_div)
  `RAO_ASSERT_NEXT(a_out_drain, clk, rst, !ctl.emit && out_valid && out_ready, !out_valid)

endmodule

`default_nettype wire

[verif/tb_replay_arithmetic_op_list.sv]
`timescale 1ns / 1ps

module tb_replay_arithmetic_op_list;

  localparam int OP_DEPTH = 64;

  typedef struct {
    logic [31:0] value;
    logic        dz;
  } acc_result_t;

  class op_list_scoreboard;
    rao_pkg::step_t steps[OP_DEPTH];
    int unsigned n_steps;
    logic [31:0] acc;
    logic [31:0] start_val;
    bit          started;
    acc_result_t due[$];
    int unsigned mismatches;
    int unsigned results_ok;
    int unsigned kept;
    int unsigned dropped;
    int unsigned dz_seen;

    function void set_start(logic [31:0] v);
      start_val = v;
    endfunction

    // signed divide, truncating toward zero, min / -1 wraps to min
    function logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] q;
      ma = a[31] ? (32'd0 - a) : a;
      mb = b[31] ? (32'd0 - b) : b;
      q = ma / mb;
      return (a[31] ^ b[31]) ? (32'd0 - q) : q;
    endfunction

    function void note_item(logic op, logic [1:0] kind, logic [31:0] opnd);
      acc_result_t r;
      logic [31:0] a;
      logic        dz;
      if (op == rao_pkg::OPC_APPEND) begin
        if (n_steps < OP_DEPTH) begin
          steps[n_steps].kind = kind;
          steps[n_steps].operand = opnd;
          n_steps++;
          kept++;
        end else begin
          dropped++;
        end
        return;
      end
      a = started ? acc : start_val;
      dz = 1'b0;
      for (int i = 0; i < n_steps; i++) begin
        unique case (steps[i].kind)
          rao_pkg::KIND_ADD: a = a + steps[i].operand;
          rao_pkg::KIND_SUB: a = a - steps[i].operand;
          rao_pkg::KIND_MUL: a = a * steps[i].operand;
          rao_pkg::KIND_DIV: begin
            if (steps[i].operand == 32'd0) dz = 1'b1;
            else a = trunc_div(a, steps[i].operand);
          end
        endcase
      end
      acc = a;
      started = 1'b1;
      r.value = a;
      r.dz = dz;
      due.push_back(r);
    endfunction

    function void check_result(logic [31:0] v, logic dz);
      acc_result_t e;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result value=%h div_by_zero=%b", $time, v, dz);
        return;
      end
      e = due.pop_front();
      if (v !== e.value || dz !== e.dz) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result: value exp %h got %h, div_by_zero exp %b got %b",
                   $time, e.value, v, e.dz, dz);
      end else begin
        results_ok++;
      end
      if (dz === 1'b1) dz_seen++;
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        opcode = rao_pkg::OPC_APPEND;
  logic [1:0]                  step_kind = rao_pkg::KIND_ADD;
  logic signed [31:0]          step_operand = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [31:0]          value;
  logic                        div_by_zero;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [rao_pkg::ADDR_W-1:0]  paddr = rao_pkg::ADDR_START_VALUE;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  op_list_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stored = 0;

  replay_arithmetic_op_list #(.OP_DEPTH(OP_DEPTH)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .step_kind(step_kind), .step_operand(step_operand),
    .out_valid(out_valid), .out_ready(out_ready),
    .value(value), .div_by_zero(div_by_zero),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_item(opcode, step_kind, step_operand);
      if (out_valid && out_ready) sb.check_result(value, div_by_zero);
    end
  end

  task automatic send_item(input logic op, input logic [1:0] kind, input logic [31:0] opnd);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    opcode <= op;
    step_kind <= kind;
    step_operand <= opnd;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic append_step(input logic [1:0] kind, input logic [31:0] opnd);
    send_item(rao_pkg::OPC_APPEND, kind, opnd);
    if (stored < OP_DEPTH) stored++;
  endtask

  task automatic apply_steps();
    send_item(rao_pkg::OPC_APPLY, 2'($urandom_range(3)), $urandom);
  endtask

  task automatic cfg_write(input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= rao_pkg::ADDR_START_VALUE;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_start(v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    unique case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5, 6: return 32'($signed($urandom_range(32)) - 16);
      default: return $urandom;
    endcase
  endfunction

  // counts only items the block acts on; appends to a full store are extra
  task automatic run_random(input int n_items, input int s_pct, input int r_pct);
    int done;
    bit is_apply;
    done = 0;
    send_idle_pct = s_pct;
    recv_idle_pct <= r_pct;
    while (done < n_items) begin
      if (stored < OP_DEPTH) is_apply = ($urandom_range(99) < 30);
      else is_apply = ($urandom_range(99) < 90);
      if (is_apply) begin
        apply_steps();
        done++;
      end else begin
        if (stored < OP_DEPTH) done++;
        append_step(2'($urandom_range(3)), pick_operand());
      end
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty store, min / -1, zero divisor, field extremes
    cfg_write(32'h8000_0000);
    apply_steps();
    append_step(rao_pkg::KIND_DIV, 32'hFFFF_FFFF);
    apply_steps();
    append_step(rao_pkg::KIND_DIV, 32'd0);
    apply_steps();
    append_step(rao_pkg::KIND_ADD, 32'h7FFF_FFFF);
    append_step(rao_pkg::KIND_SUB, 32'h8000_0000);
    append_step(rao_pkg::KIND_MUL, 32'hFFFF_FFFF);
    append_step(rao_pkg::KIND_DIV, 32'h7FFF_FFFF);
    append_step(rao_pkg::KIND_ADD, 32'h5A5A_A5A5);
    apply_steps();
    drain();

    cfg_write(32'h7FFF_FFFF);
    run_random(150, 21, 57);
    cfg_write($urandom);
    run_random(150, 57, 21);
    cfg_write(32'd0);
    run_random(150, 0, 0);

    $display("%0d results checked (%0d with a zero divisor), %0d mismatches",
             sb.results_ok + sb.mismatches, sb.dz_seen, sb.mismatches);
    $display("%0d steps stored, %0d appends dropped on a full store",
             sb.kept, sb.dropped);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #48_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
